// ===== sv/defp_pkg.sv =====
// Shared types, codes and constants of the display event frame parser.
package defp_pkg;

  // Fixed field widths
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 3;
  localparam int COORD_W     = 16;
  localparam int SLOT_W      = 17;
  localparam int SLOT_REGS   = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int HEAD_LEN    = 5;
  localparam int HEAD_IDX_W  = 3;
  localparam int RUN_W       = 2;

  // Parameter defaults
  localparam int DEF_MAX_FRAME_BYTES = 255;
  localparam int DEF_TOUCH_SLOTS     = 4;

  // Link byte codes
  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] EV_TOUCH  = 8'h65;
  localparam logic [BYTE_W-1:0] EV_COORD  = 8'h67;
  localparam logic [BYTE_W-1:0] EV_COORD2 = 8'h68;
  localparam logic [BYTE_W-1:0] EV_K66    = 8'h66;
  localparam logic [BYTE_W-1:0] EV_K70    = 8'h70;
  localparam logic [BYTE_W-1:0] EV_K71    = 8'h71;
  localparam logic [BYTE_W-1:0] EV_K86    = 8'h86;
  localparam logic [BYTE_W-1:0] EV_K87    = 8'h87;
  localparam logic [BYTE_W-1:0] EV_K88    = 8'h88;
  localparam logic [BYTE_W-1:0] EV_K89    = 8'h89;
  localparam logic [BYTE_W-1:0] EV_KFD    = 8'hFD;
  localparam logic [BYTE_W-1:0] EV_KFE    = 8'hFE;

  // Frame lengths expected for decoded events
  localparam logic [BYTE_W-1:0] TOUCH_LEN = 8'd3;
  localparam logic [BYTE_W-1:0] COORD_LEN = 8'd5;
  localparam logic [BYTE_W-1:0] TERM_LEN  = 8'd3;
  localparam logic [RUN_W-1:0]  RUN_END   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_TOUCH    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COORD    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_KNOWN    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd5;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [BYTE_W-1:0]    event_code;
    logic [BYTE_W-1:0]    frame_length;
    logic [BYTE_W-1:0]    touch_page;
    logic [BYTE_W-1:0]    touch_component;
    logic                 pressed;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [SLOT_REGS-1:0] slot_match;
  } result_t;

endpackage

// ===== sv/defp_slot_match.sv =====
// Touch slot registers and the parallel page/component compare.
module defp_slot_match import defp_pkg::*; #(
  parameter int TOUCH_SLOTS = DEF_TOUCH_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLOT_W-1:0]    cfg_wdata,
  input  logic [BYTE_W-1:0]    page,
  input  logic [BYTE_W-1:0]    component,
  output logic [SLOT_REGS-1:0] match
);

  for (genvar i = 0; i < SLOT_REGS; i++) begin : g_slot
    if (i < TOUCH_SLOTS) begin : g_reg
      logic [SLOT_W-1:0] slot_r;

      // Load the slot on a write to its index
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          slot_r <= '0;
        end else if (cfg_we && (cfg_index == CFG_IDX_W'(i))) begin
          slot_r <= cfg_wdata;
        end
      end

      // Match when enabled and both ids agree
      assign match[i] = slot_r[SLOT_W-1] &&
                        (slot_r[2*BYTE_W-1:BYTE_W] == page) &&
                        (slot_r[BYTE_W-1:0] == component);
    end else begin : g_none
      assign match[i] = 1'b0;
    end
  end

endmodule

// ===== sv/defp_parser.sv =====
// Frame state tracking and end-of-frame decode for one byte per cycle while accept is high.
module defp_parser import defp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic [SLOT_REGS-1:0] slot_match,
  output logic [BYTE_W-1:0]    head_page,
  output logic [BYTE_W-1:0]    head_component,
  output logic                 res_valid,
  output result_t              res
);

  localparam logic [BYTE_W-1:0] MAX_BYTES = BYTE_W'(MAX_FRAME_BYTES);

  logic              collecting_r, collecting_nxt;
  logic [BYTE_W-1:0] held_event_r, held_event_nxt;
  logic [BYTE_W-1:0] byte_count_r, byte_count_nxt;
  logic [RUN_W-1:0]  ff_run_r, ff_run_nxt;
  logic [BYTE_W-1:0] head_r [HEAD_LEN];

  logic              is_fill;
  logic              head_we;
  logic [BYTE_W-1:0] count_inc;
  logic [RUN_W-1:0]  run_inc;
  logic [BYTE_W-1:0] frame_len;
  logic              other_known;

  assign is_fill     = (rx_byte == FILL_BYTE);
  assign count_inc   = byte_count_r + 8'd1;
  assign run_inc     = is_fill ? ff_run_r + 2'd1 : '0;
  assign frame_len   = count_inc - TERM_LEN;
  assign head_we     = accept && collecting_r && (byte_count_r < BYTE_W'(HEAD_LEN));
  assign other_known = held_event_r inside {EV_K66, EV_K70, EV_K71, EV_K86, EV_K87,
                                            EV_K88, EV_K89, EV_KFD, EV_KFE};

  assign head_page      = head_r[0];
  assign head_component = head_r[1];

  // Advance the frame state and build the result for a terminating byte or an overlong frame
  always_comb begin
    collecting_nxt = collecting_r;
    held_event_nxt = held_event_r;
    byte_count_nxt = byte_count_r;
    ff_run_nxt     = ff_run_r;
    res_valid      = 1'b0;
    res            = '0;

    if (accept) begin
      if (!collecting_r) begin
        // Drop filler; any other byte opens a frame
        if (!is_fill) begin
          collecting_nxt = 1'b1;
          held_event_nxt = rx_byte;
          byte_count_nxt = '0;
          ff_run_nxt     = '0;
        end
      end else begin
        res.event_code = held_event_r;
        byte_count_nxt = count_inc;
        ff_run_nxt     = run_inc;
        if (run_inc == RUN_END) begin
          collecting_nxt   = 1'b0;
          ff_run_nxt       = '0;
          res_valid        = 1'b1;
          res.frame_length = frame_len;
          if (held_event_r == EV_TOUCH) begin
            if (frame_len != TOUCH_LEN) begin
              res.status = ST_BAD_LEN;
            end else begin
              res.status          = ST_TOUCH;
              res.touch_page      = head_r[0];
              res.touch_component = head_r[1];
              res.pressed         = (head_r[2] != '0);
              res.slot_match      = slot_match;
            end
          end else if (held_event_r == EV_COORD || held_event_r == EV_COORD2) begin
            if (frame_len != COORD_LEN) begin
              res.status = ST_BAD_LEN;
            end else begin
              res.status  = ST_COORD;
              res.coord_x = {head_r[0], head_r[1]};
              res.coord_y = {head_r[2], head_r[3]};
              res.pressed = (head_r[4] != '0);
            end
          end else if (other_known) begin
            res.status = ST_KNOWN;
          end else begin
            res.status = ST_UNKNOWN;
          end
        end else if (count_inc >= MAX_BYTES) begin
          // Too long without a terminator
          collecting_nxt   = 1'b0;
          ff_run_nxt       = '0;
          res_valid        = 1'b1;
          res.status       = ST_OVERFLOW;
          res.frame_length = MAX_BYTES;
        end
      end
    end
  end

  // Hold the frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      held_event_r <= '0;
      byte_count_r <= '0;
      ff_run_r     <= '0;
    end else begin
      collecting_r <= collecting_nxt;
      held_event_r <= held_event_nxt;
      byte_count_r <= byte_count_nxt;
      ff_run_r     <= ff_run_nxt;
    end
  end

  // Capture the first data bytes of the frame
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_r[byte_count_r[HEAD_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

// ===== sv/defp_out_buf.sv =====
// Result register with a skid entry so input keeps flowing under stall until the skid entry fills.
module defp_out_buf import defp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_v_r;
  logic    skid_v_r;
  result_t out_d_r;
  result_t skid_d_r;
  logic    pop;

  assign pop       = out_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  // Track occupancy of the two entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (out_v_r && !pop) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  // Move payload: skid drains first, else a new result lands where free
  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (out_v_r && !pop) begin
        skid_d_r <= push_data;
      end else begin
        out_d_r <= push_data;
      end
    end
  end

endmodule

// ===== sv/display_event_frame_parser_core.sv =====
// Top level of the display event frame parser.
//
// Usage: bytes from the display link enter on in_rx_byte with in_valid; a byte
// transfers at a clock edge with in_valid high and in_stall low. Idle filler
// 0xFF is dropped, the next byte is the event code, and data bytes follow
// until three 0xFF in a row or until MAX_FRAME_BYTES bytes end the frame.
// At most one result transfers per byte on the out_ channel (out_valid high,
// out_stall low): status, event code, length, touch or coordinate fields and
// the mask of matching touch slots written through the cfg_ port.
// Throughput: one byte per cycle while in_stall is low; the decode sits
// between the frame state registers and the result register. Latency: the
// result of a terminating byte shows on out_valid in the cycle after that
// byte transfers when the result register is free, otherwise right after
// the result ahead of it transfers.
// Stall: a result register plus one skid entry absorb results while out_stall
// is high; in_stall rises only once both are full, and drops as it drains.
// Reset (rst_n low, synchronous) returns the parser to idle, empties the
// result buffer and clears all touch slots. Write slots only while idle.
module display_event_frame_parser_core import defp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
  parameter int TOUCH_SLOTS     = DEF_TOUCH_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SLOT_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  out_status,
  output logic [BYTE_W-1:0]    out_event_code,
  output logic [BYTE_W-1:0]    out_frame_length,
  output logic [BYTE_W-1:0]    out_touch_page,
  output logic [BYTE_W-1:0]    out_touch_component,
  output logic                 out_pressed,
  output logic [COORD_W-1:0]   out_coord_x,
  output logic [COORD_W-1:0]   out_coord_y,
  output logic [SLOT_REGS-1:0] out_slot_match
);

  logic                 accept;
  logic                 buf_full;
  logic [BYTE_W-1:0]    head_page;
  logic [BYTE_W-1:0]    head_component;
  logic [SLOT_REGS-1:0] slot_match;
  logic                 res_valid;
  result_t              res;
  result_t              out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  defp_slot_match #(
    .TOUCH_SLOTS (TOUCH_SLOTS)
  ) u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .page      (head_page),
    .component (head_component),
    .match     (slot_match)
  );

  defp_parser #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .rx_byte        (in_rx_byte),
    .slot_match     (slot_match),
    .head_page      (head_page),
    .head_component (head_component),
    .res_valid      (res_valid),
    .res            (res)
  );

  defp_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Split the result onto its ports
  assign out_status          = out_data.status;
  assign out_event_code      = out_data.event_code;
  assign out_frame_length    = out_data.frame_length;
  assign out_touch_page      = out_data.touch_page;
  assign out_touch_component = out_data.touch_component;
  assign out_pressed         = out_data.pressed;
  assign out_coord_x         = out_data.coord_x;
  assign out_coord_y         = out_data.coord_y;
  assign out_slot_match      = out_data.slot_match;

endmodule
